// ===== hdl/bapc_pkg.sv =====
// Shared types, codes and a helper function of the bump allocator page commit unit.
package bapc_pkg;

  localparam int ADDR_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam int SIZE_W   = 32;
  localparam int ALIGN_W  = 5;
  localparam int MASK_W   = 32;
  localparam int OFF_W    = 32;
  localparam int BYTES_W  = 33;
  localparam int SHIFT_W  = 5;
  localparam int CAPP_W   = 21;
  localparam int PAGE_W   = 17;
  localparam int APB_DW   = 32;
  localparam int PADDR_W  = 3;
  localparam int REG_IDX_W = 1;

  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MIN   = 5'd8;
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MAX   = 5'd16;
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = 5'd12;
  localparam logic [CAPP_W-1:0]  CAP_PAGES_RESET  = 21'd1048576;

  localparam logic [REG_IDX_W-1:0] REG_PAGE_SHIFT     = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY_PAGES = 1'b1;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_PURGE  = 2'd1,
    MODE_REWIND = 2'd2,
    MODE_RESET  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_ZERO    = 2'd1,
    STATUS_NOSPACE = 2'd2,
    STATUS_REWIND  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_COMMIT   = 2'd1,
    ACT_DECOMMIT = 2'd2
  } action_t;

  typedef struct packed {
    mode_t               mode;
    logic [SIZE_W-1:0]   request_size;
    logic [ALIGN_W-1:0]  align_log2;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [OFF_W-1:0]    block_offset;
    action_t             page_action;
    logic [OFF_W-1:0]    page_range_offset;
    logic [BYTES_W-1:0]  page_range_bytes;
  } rsp_t;

  // Classified request handed from the front end to the execution side.
  typedef struct packed {
    mode_t               mode;
    logic                size_zero;
    logic [SIZE_W-1:0]   size;
    logic [MASK_W-1:0]   amask;
  } cmd_t;

  function automatic logic [SHIFT_W-1:0] eff_shift(input logic [SHIFT_W-1:0] s);
    logic [SHIFT_W-1:0] r;
    r = s;
    if (s < PAGE_SHIFT_MIN) r = PAGE_SHIFT_MIN;
    if (s > PAGE_SHIFT_MAX) r = PAGE_SHIFT_MAX;
    return r;
  endfunction

endpackage

// ===== hdl/bump_allocator_page_commit_unit.sv =====
// Top level of the bump allocator with page commit.
//
// Requests (mode, request_size, align_log2) arrive on req_valid/req_ready and
// each produces exactly one response (status, block offset, page action and
// range) on rsp_valid/rsp_ready, in order. A request is registered in the
// front end, passes a short command queue and is executed against the bump
// offset and committed end as it leaves the queue; the result is held in a
// response register. One request per cycle is sustained while the receiver
// takes responses; that rate rests on both offset registers being updated
// for each command taken from the queue.
// When the receiver stalls, the response register holds its value and the
// queue and front end keep taking requests until they fill, then req_ready
// drops. Reset (rst, synchronous) clears both offsets, empties the queue and
// restores page_shift to 12 and capacity_pages to 1048576. The APB port
// reaches page_shift at address 0 and capacity_pages at address 4; write it
// only while no request is in flight.
module bump_allocator_page_commit_unit #(
  parameter int ADDR_WIDTH  = bapc_pkg::ADDR_WIDTH_DEF,
  parameter int QUEUE_DEPTH = bapc_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  bapc_pkg::req_t                req_data,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output bapc_pkg::rsp_t                rsp_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bapc_pkg::PADDR_W-1:0]  paddr,
  input  logic [bapc_pkg::APB_DW-1:0]   pwdata,
  output logic [bapc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  logic [bapc_pkg::SHIFT_W-1:0] page_shift_eff;
  logic [ADDR_WIDTH:0]          cap_bytes;
  logic                         push;
  logic                         push_ready;
  bapc_pkg::cmd_t               push_cmd;
  logic                         pop_valid;
  logic                         pop;
  bapc_pkg::cmd_t               pop_cmd;

  bapc_regs #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .page_shift_eff (page_shift_eff),
    .cap_bytes      (cap_bytes)
  );

  bapc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_data   (req_data),
    .push       (push),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  bapc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  bapc_back #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (pop_valid),
    .cmd_pop        (pop),
    .cmd            (pop_cmd),
    .page_shift_eff (page_shift_eff),
    .cap_bytes      (cap_bytes),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp_data       (rsp_data)
  );

endmodule

// ===== hdl/bapc_regs.sv =====
// Configuration registers on the APB port, with the effective page shift and byte capacity.
module bapc_regs #(
  parameter int ADDR_WIDTH = bapc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bapc_pkg::PADDR_W-1:0]      paddr,
  input  logic [bapc_pkg::APB_DW-1:0]       pwdata,
  output logic [bapc_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  output logic [bapc_pkg::SHIFT_W-1:0]      page_shift_eff,
  output logic [ADDR_WIDTH:0]               cap_bytes
);

  localparam int RAW_W = ((bapc_pkg::CAPP_W + 16) > (ADDR_WIDTH + 1))
                         ? (bapc_pkg::CAPP_W + 16) : (ADDR_WIDTH + 1);

  logic [bapc_pkg::SHIFT_W-1:0]   page_shift;
  logic [bapc_pkg::CAPP_W-1:0]    capacity_pages;
  logic [bapc_pkg::SHIFT_W-1:0]   page_shift_next;
  logic [bapc_pkg::CAPP_W-1:0]    capacity_pages_next;
  logic [bapc_pkg::SHIFT_W-1:0]   eff_next;
  logic [RAW_W-1:0]               raw_cap;
  logic [RAW_W-1:0]               limit;
  logic [ADDR_WIDTH:0]            cap_next;
  logic                           wr;
  logic [bapc_pkg::REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[2 +: bapc_pkg::REG_IDX_W];

  always_comb begin
    page_shift_next     = page_shift;
    capacity_pages_next = capacity_pages;
    if (wr) begin
      unique case (idx)
        bapc_pkg::REG_PAGE_SHIFT:     page_shift_next = pwdata[bapc_pkg::SHIFT_W-1:0];
        bapc_pkg::REG_CAPACITY_PAGES: capacity_pages_next = pwdata[bapc_pkg::CAPP_W-1:0];
        default: ;
      endcase
    end
    // Reset values go through the same path so the derived registers match them.
    if (rst) begin
      page_shift_next     = bapc_pkg::PAGE_SHIFT_RESET;
      capacity_pages_next = bapc_pkg::CAP_PAGES_RESET;
    end
  end

  // The byte capacity is derived when a register is written or reset, off the request path.
  always_comb begin
    eff_next = bapc_pkg::eff_shift(page_shift_next);
    raw_cap  = RAW_W'(capacity_pages_next) << eff_next;
    limit    = RAW_W'(1) << ADDR_WIDTH;
    cap_next = (raw_cap > limit) ? (ADDR_WIDTH+1)'(limit) : (ADDR_WIDTH+1)'(raw_cap);
  end

  always_ff @(posedge clk) begin
    page_shift     <= page_shift_next;
    capacity_pages <= capacity_pages_next;
    page_shift_eff <= eff_next;
    cap_bytes      <= cap_next;
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      bapc_pkg::REG_PAGE_SHIFT:     prdata = bapc_pkg::APB_DW'(page_shift);
      bapc_pkg::REG_CAPACITY_PAGES: prdata = bapc_pkg::APB_DW'(capacity_pages);
      default: ;
    endcase
  end

endmodule

// ===== hdl/bapc_front.sv =====
// Front end: takes requests, decodes them and builds the alignment mask.
module bapc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bapc_pkg::req_t    req_data,
  output logic              push,
  input  logic              push_ready,
  output bapc_pkg::cmd_t    push_cmd
);

  logic           busy;
  bapc_pkg::cmd_t cmd;
  bapc_pkg::cmd_t cmd_next;
  logic           take;

  assign req_ready = !busy || push_ready;
  assign take      = req_valid && req_ready;
  assign push      = busy;
  assign push_cmd  = cmd;

  always_comb begin
    cmd_next.mode      = req_data.mode;
    cmd_next.size      = req_data.request_size;
    cmd_next.size_zero = (req_data.request_size == '0);
    cmd_next.amask     = (bapc_pkg::MASK_W'(1) << req_data.align_log2) - bapc_pkg::MASK_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      busy <= 1'b1;
    end else if (push_ready) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== hdl/bapc_queue.sv =====
// Short command queue between the front end and the execution side.
module bapc_queue #(
  parameter int DEPTH = bapc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              push_ready,
  input  bapc_pkg::cmd_t    push_cmd,
  output logic              pop_valid,
  input  logic              pop,
  output bapc_pkg::cmd_t    pop_cmd
);

  // DEPTH must be at least 2.
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bapc_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/bapc_back.sv =====
// Execution side: holds the bump offset and committed end and registers each result.
module bapc_back #(
  parameter int ADDR_WIDTH = bapc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  bapc_pkg::cmd_t                cmd,
  input  logic [bapc_pkg::SHIFT_W-1:0]  page_shift_eff,
  input  logic [ADDR_WIDTH:0]           cap_bytes,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output bapc_pkg::rsp_t                rsp_data
);

  localparam int SW = ADDR_WIDTH + 1;
  // Wide enough that aligned start, block end and the committed end after growth never wrap.
  localparam int EW = ((ADDR_WIDTH > 32) ? ADDR_WIDTH : 32) + 3;

  logic [SW-1:0]              alloc_offset;
  logic [SW-1:0]              committed_end;
  logic [SW-1:0]              alloc_offset_next;
  logic [SW-1:0]              committed_end_next;
  bapc_pkg::rsp_t             rsp_next;
  logic                       take;

  logic [bapc_pkg::PAGE_W-1:0] page_w;
  logic [EW-1:0] page_e, page_m1_e, amask_e, size_e, alloc_e, comm_e, cap_e;
  logic [EW-1:0] aligned, blk_end, need, grow, new_end, acur, gap;

  assign take    = cmd_valid && (!rsp_valid || rsp_ready);
  assign cmd_pop = take;

  always_comb begin
    page_w    = bapc_pkg::PAGE_W'(1) << page_shift_eff;
    page_e    = EW'(page_w);
    page_m1_e = page_e - EW'(1);
    amask_e   = EW'(cmd.amask);
    size_e    = EW'(cmd.size);
    alloc_e   = EW'(alloc_offset);
    comm_e    = EW'(committed_end);
    cap_e     = EW'(cap_bytes);

    aligned   = (alloc_e + amask_e) & ~amask_e;
    blk_end   = aligned + size_e;
    need      = blk_end - comm_e;
    grow      = (need + page_m1_e) & ~page_m1_e;
    new_end   = comm_e + grow;

    acur      = (alloc_e + page_m1_e) & ~page_m1_e;
    gap       = comm_e - acur;
  end

  always_comb begin
    rsp_next.status            = bapc_pkg::STATUS_OK;
    rsp_next.block_offset      = '0;
    rsp_next.page_action       = bapc_pkg::ACT_NONE;
    rsp_next.page_range_offset = '0;
    rsp_next.page_range_bytes  = '0;
    alloc_offset_next          = alloc_offset;
    committed_end_next         = committed_end;

    unique case (cmd.mode)
      bapc_pkg::MODE_ALLOC: begin
        if (cmd.size_zero) begin
          rsp_next.status = bapc_pkg::STATUS_ZERO;
        end else if (blk_end > cap_e) begin
          rsp_next.status = bapc_pkg::STATUS_NOSPACE;
        end else if (blk_end > comm_e) begin
          if (new_end > cap_e) begin
            rsp_next.status = bapc_pkg::STATUS_NOSPACE;
          end else begin
            rsp_next.page_action       = bapc_pkg::ACT_COMMIT;
            rsp_next.page_range_offset = bapc_pkg::OFF_W'(comm_e);
            rsp_next.page_range_bytes  = bapc_pkg::BYTES_W'(grow);
            rsp_next.block_offset      = bapc_pkg::OFF_W'(aligned);
            committed_end_next         = SW'(new_end);
            alloc_offset_next          = SW'(blk_end);
          end
        end else begin
          rsp_next.block_offset = bapc_pkg::OFF_W'(aligned);
          alloc_offset_next     = SW'(blk_end);
        end
      end
      bapc_pkg::MODE_PURGE: begin
        // Only decommit when more than one page lies past the rounded-up offset.
        if ((comm_e > acur) && (gap > page_e)) begin
          rsp_next.page_action       = bapc_pkg::ACT_DECOMMIT;
          rsp_next.page_range_offset = bapc_pkg::OFF_W'(acur);
          rsp_next.page_range_bytes  = bapc_pkg::BYTES_W'(gap & ~page_m1_e);
          committed_end_next         = SW'(acur);
        end
      end
      bapc_pkg::MODE_REWIND: begin
        if (size_e > alloc_e) begin
          rsp_next.status = bapc_pkg::STATUS_REWIND;
        end else begin
          alloc_offset_next = SW'(alloc_e - size_e);
        end
      end
      bapc_pkg::MODE_RESET: begin
        alloc_offset_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_offset  <= '0;
      committed_end <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (take) begin
        alloc_offset  <= alloc_offset_next;
        committed_end <= committed_end_next;
        rsp_valid     <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp_data <= rsp_next;
    end
  end

endmodule
